>>> rtl/lfsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfsd_pkg
// Register map, field widths and reset values of the serial frame deframer.
// ---------------------------------------------------------------------------
package lfsd_pkg;

	localparam int BYTE_W     = 8;
	localparam int OVH_W      = 4;
	localparam int OFFSET_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int TOTAL_W    = 17;   // 16-bit length plus 4-bit overhead

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [OVH_W-1:0]     ovh_t;
	typedef logic [OFFSET_W-1:0]  offset_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [TOTAL_W-1:0]   total_t;

	// configuration register indexes
	localparam cfg_idx_t REG_START_BYTE     = 2'd0;
	localparam cfg_idx_t REG_OVERHEAD_BYTES = 2'd1;

	localparam byte_t START_BYTE_RST     = 8'hA5;
	localparam ovh_t  OVERHEAD_BYTES_RST = 4'd9;

endpackage

`default_nettype wire

>>> rtl/length_framed_serial_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// length_framed_serial_deframer
// Start-of-frame, length-prefixed byte deframer for a received serial stream.
// ---------------------------------------------------------------------------
// Bytes enter one word per cycle while in_stall is low. While hunting, every
// byte that differs from start_byte is dropped with no output. The start byte
// opens a frame at offset 0 (frame_first), the next two bytes give the
// payload length high byte first, and the frame runs to payload length plus
// overhead_bytes bytes, the final one marked frame_last. When the declared
// frame exceeds MAX_FRAME, the second length byte comes out with length_error
// set and the block hunts again. byte_offset is the position modulo 128. The
// block sustains one byte per cycle while out_stall does not hold the output
// register: a byte is registered at the input, passes the position counter and
// one 17-bit add and compare, and lands in the output register. Configuration
// writes are always ready and must only be issued while the block is idle.
module length_framed_serial_deframer #(
	parameter int MAX_FRAME = 128
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// byte input
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire  lfsd_pkg::byte_t     rx_byte,
	// frame output
	output logic                      out_valid,
	input  wire                       out_stall,
	output lfsd_pkg::byte_t           frame_byte,
	output lfsd_pkg::offset_t         byte_offset,
	output logic                      frame_first,
	output logic                      frame_last,
	output logic                      length_error,
	// configuration write
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire  lfsd_pkg::cfg_idx_t  cfg_index,
	input  wire  lfsd_pkg::byte_t     cfg_data
);
	import lfsd_pkg::*;

	localparam int PW = $clog2(MAX_FRAME);       // position within a frame
	localparam int LW = $clog2(MAX_FRAME + 1);   // frame length up to MAX_FRAME

	localparam logic [PW-1:0] POS_HUNT   = '0;
	localparam logic [PW-1:0] POS_LEN_HI = PW'(1);
	localparam logic [PW-1:0] POS_LEN_LO = PW'(2);
	localparam logic [PW-1:0] POS_BODY   = PW'(3);

	// configuration registers
	byte_t start_byte_q;
	ovh_t  overhead_q;

	// parser state
	logic [PW-1:0] pos_q;
	byte_t         len_hi_q;
	logic [LW-1:0] frame_len_q;

	// input register
	logic  valid_s1;
	byte_t byte_s1;

	// output register
	logic    out_valid_q;
	byte_t   frame_byte_q;
	offset_t offset_q;
	logic    first_q;
	logic    last_q;
	logic    err_q;

	// ------------------------------------------------------------------
	// Configuration: always ready, ignore indexes beyond the map.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			overhead_q   <= OVERHEAD_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_BYTE:     start_byte_q <= cfg_data;
				REG_OVERHEAD_BYTES: overhead_q   <= cfg_data[OVH_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Parse the byte held in the input register.
	// ------------------------------------------------------------------
	total_t        total;
	logic [LW-1:0] pos_next_ext;
	logic          no_result;
	logic          out_free;
	logic          advance_s1;
	logic          take_in;
	logic [PW-1:0] pos_d;
	logic          last_d;
	logic          err_d;

	assign total        = {len_hi_q, byte_s1} + TOTAL_W'(overhead_q);
	assign pos_next_ext = LW'(pos_q) + LW'(1);

	always_comb begin
		no_result = 1'b0;
		last_d    = 1'b0;
		err_d     = 1'b0;
		pos_d     = pos_q;
		case (pos_q)
			POS_HUNT: begin
				if (byte_s1 == start_byte_q) begin
					pos_d = POS_LEN_HI;
				end else begin
					no_result = 1'b1;
				end
			end
			POS_LEN_HI: begin
				pos_d = POS_LEN_LO;
			end
			POS_LEN_LO: begin
				if (total > TOTAL_W'(MAX_FRAME)) begin
					err_d = 1'b1;
					pos_d = POS_HUNT;
				end else if (total <= TOTAL_W'(3)) begin
					last_d = 1'b1;
					pos_d  = POS_HUNT;
				end else begin
					pos_d = POS_BODY;
				end
			end
			default: begin
				if (pos_next_ext >= frame_len_q) begin
					last_d = 1'b1;
					pos_d  = POS_HUNT;
				end else begin
					pos_d = pos_q + PW'(1);
				end
			end
		endcase
	end

	// Advance when the byte is dropped or the output register can take it.
	assign out_free   = !out_valid_q || !out_stall;
	assign advance_s1 = valid_s1 && (no_result || out_free);
	assign in_stall   = valid_s1 && !advance_s1;
	assign take_in    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= rx_byte;
		end
	end

	// Parser state moves with each advanced byte; hunting clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HUNT;
			len_hi_q    <= '0;
			frame_len_q <= '0;
		end else if (advance_s1) begin
			pos_q <= pos_d;
			if (pos_d == POS_HUNT) begin
				len_hi_q    <= '0;
				frame_len_q <= '0;
			end else if (pos_q == POS_LEN_HI) begin
				len_hi_q <= byte_s1;
			end else if (pos_q == POS_LEN_LO) begin
				frame_len_q <= total[LW-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold while stalled, load on each emitted byte.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1 && !no_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && !no_result) begin
			frame_byte_q <= byte_s1;
			offset_q     <= OFFSET_W'(pos_q);
			first_q      <= (pos_q == POS_HUNT);
			last_q       <= last_d;
			err_q        <= err_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_byte   = frame_byte_q;
	assign byte_offset  = offset_q;
	assign frame_first  = first_q;
	assign frame_last   = last_q;
	assign length_error = err_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_last_err_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(last_q && err_q))
		else $error("frame_last and length_error set together");

	a_first_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && first_q) |-> (offset_q == '0))
		else $error("start byte with nonzero offset");

	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (last_q || err_q)) |-> (pos_q == POS_HUNT))
		else $error("parser not hunting after frame end");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !no_result && out_valid_q && out_stall) |-> in_stall)
		else $error("input taken while output blocked");

endmodule

`default_nettype wire
